// ----- src/life_automaton_torus_step_top_assert.svh -----
// Assertion macros for the toroidal life automaton top level.
// No dependencies; included by life_automaton_torus_step_top.
`ifndef LIFE_AUTOMATON_TORUS_STEP_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_STEP_TOP_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define LATS_ASSERT_NOW(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a in this cycle implies b in the next cycle
`define LATS_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- src/lats_pkg.sv -----
// Shared types and constants for the toroidal life automaton.
// No dependencies; used by lats_cell_rule and life_automaton_torus_step_top.
`timescale 1ns / 1ps

package lats_pkg;

   localparam int CELL_IDX_W = 7;

   typedef logic [1:0] lats_mode_type;

   localparam lats_mode_type MODE_TOGGLE = 2'd0;
   localparam lats_mode_type MODE_SET    = 2'd1;
   localparam lats_mode_type MODE_READ   = 2'd2;
   localparam lats_mode_type MODE_GEN    = 2'd3;

   localparam logic [3:0] NB_BORN = 4'd3;
   localparam logic [3:0] NB_KEEP = 4'd2;

   // 3x3 neighbourhood, each row {left, centre, right}
   typedef struct packed {
      logic [2:0] up;
      logic [2:0] mid;
      logic [2:0] dn;
   } lats_window_type;

endpackage

// ----- src/life_automaton_torus_step_top.sv -----
// Top level of the toroidal life automaton: grid memory, sequencer, result port.
// Depends on lats_pkg, lats_cell_rule and life_automaton_torus_step_top_assert.svh.
`timescale 1ns / 1ps
`include "life_automaton_torus_step_top_assert.svh"

// Grid of GRID_ROWS x GRID_COLS cells held one row per memory word, wrapping at its
// edges. After reset a clearing pass over all rows runs with busy high. An item
// is taken when start is high and busy is low; its single result appears on the rsp_
// ports for one cycle with rsp_valid high and must be captured then, as it cannot be
// held off. Toggle, set and read first wrap the row and column into the grid by
// repeated subtraction, one per step on each coordinate, then read the row, write back
// any edit and issue the result. In a generation the single rule unit visits one cell
// per cycle of a row's sweep while the three row registers rotate past it, and each row
// costs one write and one read of the single-port-pair row memory. busy stays high until
// the result has been issued.
module life_automaton_torus_step_top #(
   parameter int GRID_ROWS = 128,
   parameter int GRID_COLS = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  lats_pkg::lats_mode_type               req_mode,
   input  logic [lats_pkg::CELL_IDX_W-1:0]       req_cell_row,
   input  logic [lats_pkg::CELL_IDX_W-1:0]       req_cell_col,
   input  logic                                  req_set_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_cell_state,
   output logic                                  rsp_generation_done
);
   import lats_pkg::*;

   localparam int RA_W = $clog2(GRID_ROWS);
   localparam int CA_W = $clog2(GRID_COLS);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_WRAP  = 4'd2;
   localparam logic [3:0] ST_EDIT  = 4'd3;
   localparam logic [3:0] ST_GRD0  = 4'd4;
   localparam logic [3:0] ST_GRD1  = 4'd5;
   localparam logic [3:0] ST_GRD2  = 4'd6;
   localparam logic [3:0] ST_GRD3  = 4'd7;
   localparam logic [3:0] ST_SWEEP = 4'd8;
   localparam logic [3:0] ST_GWR   = 4'd9;
   localparam logic [3:0] ST_GLD   = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [RA_W-1:0]       row_cnt_ff, row_cnt_in;
   logic [CA_W-1:0]       col_cnt_ff, col_cnt_in;
   lats_mode_type         mode_ff, mode_in;
   logic [CELL_IDX_W-1:0] row_ff, row_in;
   logic [CELL_IDX_W-1:0] col_ff, col_in;
   logic                  val_ff, val_in;
   logic [GRID_COLS-1:0]  up_ff, up_in;
   logic [GRID_COLS-1:0]  cur_ff, cur_in;
   logic [GRID_COLS-1:0]  dn_ff, dn_in;
   logic [GRID_COLS-1:0]  row0_ff, row0_in;
   logic [GRID_COLS-1:0]  nrow_ff, nrow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_cell_ff, rsp_cell_in;
   logic                  rsp_gen_ff, rsp_gen_in;

   logic [GRID_COLS-1:0]  grid_mem [GRID_ROWS];
   logic [GRID_COLS-1:0]  rd_data_ff;
   logic [RA_W-1:0]       rd_addr;
   logic                  wr_en;
   logic [RA_W-1:0]       wr_addr;
   logic [GRID_COLS-1:0]  wr_data;

   lats_window_type       window;
   logic                  new_cell;
   logic                  row_over, col_over;
   logic [RA_W:0]         next2;
   logic                  use_row0;
   logic [RA_W-1:0]       next2_addr;
   logic [RA_W-1:0]       row_idx;
   logic [CA_W-1:0]       col_idx;
   logic                  old_bit, edit_bit;
   logic [GRID_COLS-1:0]  row_edit;

   assign window.up  = {up_ff[GRID_COLS-1], up_ff[0], up_ff[1]};
   assign window.mid = {cur_ff[GRID_COLS-1], cur_ff[0], cur_ff[1]};
   assign window.dn  = {dn_ff[GRID_COLS-1], dn_ff[0], dn_ff[1]};

   lats_cell_rule u_rule (
      .window (window),
      .alive  (new_cell)
   );

   assign row_over   = 32'(row_ff) >= 32'(GRID_ROWS);
   assign col_over   = 32'(col_ff) >= 32'(GRID_COLS);
   assign row_idx    = RA_W'(row_ff);
   assign col_idx    = CA_W'(col_ff);
   assign next2      = {1'b0, row_cnt_ff} + (RA_W+1)'(2);
   assign use_row0   = next2 == (RA_W+1)'(GRID_ROWS);
   assign next2_addr = use_row0 ? '0 : RA_W'(next2);
   assign old_bit    = rd_data_ff[col_idx];

   always_comb begin
      case (mode_ff)
         MODE_TOGGLE: edit_bit = ~old_bit;
         MODE_SET:    edit_bit = val_ff;
         default:     edit_bit = old_bit;
      endcase
      row_edit          = rd_data_ff;
      row_edit[col_idx] = edit_bit;
   end

   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      mode_in      = mode_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      up_in        = up_ff;
      cur_in       = cur_ff;
      dn_in        = dn_ff;
      row0_in      = row0_ff;
      nrow_in      = nrow_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = rsp_cell_ff;
      rsp_gen_in   = rsp_gen_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = row_cnt_ff;
      wr_data      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               row_in   = req_cell_row;
               col_in   = req_cell_col;
               val_in   = req_set_value;
               state_in = (req_mode == MODE_GEN) ? ST_GRD0 : ST_WRAP;
            end
         end
         ST_CLEAR: begin
            wr_en      = 1'b1;
            row_cnt_in = row_cnt_ff + RA_W'(1);
            if (row_cnt_ff == RA_W'(GRID_ROWS - 1)) begin
               row_cnt_in = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_WRAP: begin
            // one subtract per step on each coordinate until both lie in the grid
            if (row_over || col_over) begin
               if (row_over) begin
                  row_in = row_ff - CELL_IDX_W'(GRID_ROWS);
               end
               if (col_over) begin
                  col_in = col_ff - CELL_IDX_W'(GRID_COLS);
               end
            end else begin
               rd_addr  = row_idx;
               state_in = ST_EDIT;
            end
         end
         ST_EDIT: begin
            wr_en        = mode_ff != MODE_READ;
            wr_addr      = row_idx;
            wr_data      = row_edit;
            rsp_valid_in = 1'b1;
            rsp_cell_in  = edit_bit;
            rsp_gen_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_GRD0: begin
            rd_addr  = RA_W'(GRID_ROWS - 1);
            state_in = ST_GRD1;
         end
         ST_GRD1: begin
            up_in    = rd_data_ff;
            rd_addr  = '0;
            state_in = ST_GRD2;
         end
         ST_GRD2: begin
            cur_in   = rd_data_ff;
            row0_in  = rd_data_ff;
            rd_addr  = RA_W'(1);
            state_in = ST_GRD3;
         end
         ST_GRD3: begin
            dn_in      = rd_data_ff;
            row_cnt_in = '0;
            col_cnt_in = '0;
            state_in   = ST_SWEEP;
         end
         ST_SWEEP: begin
            up_in      = {up_ff[0], up_ff[GRID_COLS-1:1]};
            cur_in     = {cur_ff[0], cur_ff[GRID_COLS-1:1]};
            dn_in      = {dn_ff[0], dn_ff[GRID_COLS-1:1]};
            nrow_in    = {new_cell, nrow_ff[GRID_COLS-1:1]};
            col_cnt_in = col_cnt_ff + CA_W'(1);
            if (col_cnt_ff == CA_W'(GRID_COLS - 1)) begin
               col_cnt_in = '0;
               state_in   = ST_GWR;
            end
         end
         ST_GWR: begin
            wr_en   = 1'b1;
            wr_data = nrow_ff;
            rd_addr = next2_addr;
            if (row_cnt_ff == RA_W'(GRID_ROWS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = 1'b0;
               rsp_gen_in   = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_GLD;
            end
         end
         ST_GLD: begin
            up_in      = cur_ff;
            cur_in     = dn_ff;
            dn_in      = use_row0 ? row0_ff : rd_data_ff;
            row_cnt_in = row_cnt_ff + RA_W'(1);
            state_in   = ST_SWEEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      up_ff       <= up_in;
      cur_ff      <= cur_in;
      dn_ff       <= dn_in;
      row0_ff     <= row0_in;
      nrow_ff     <= nrow_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_gen_ff  <= rsp_gen_in;
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_state      = rsp_cell_ff;
   assign rsp_generation_done = rsp_gen_ff;

   `LATS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "item taken but not busy")
   `LATS_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result issued while busy")
   `LATS_ASSERT_NOW(a_gen_zero, clock, reset, rsp_valid && rsp_generation_done, !rsp_cell_state, "generation result carries a cell")
   `LATS_ASSERT_NOW(a_edit_wrapped, clock, reset, state_ff == ST_EDIT, !row_over && !col_over, "edit address outside grid")

endmodule

// ----- src/lats_cell_rule.sv -----
// B3/S23 update of one cell from its 3x3 neighbourhood.
// Depends on lats_pkg.
`timescale 1ns / 1ps

module lats_cell_rule (
   input  lats_pkg::lats_window_type window,
   output logic                      alive
);
   import lats_pkg::*;

   logic [3:0] count;

   assign count = 4'(window.up[2]) + 4'(window.up[1]) + 4'(window.up[0])
                + 4'(window.mid[2]) + 4'(window.mid[0])
                + 4'(window.dn[2]) + 4'(window.dn[1]) + 4'(window.dn[0]);

   assign alive = (count == NB_BORN) || (window.mid[1] && (count == NB_KEEP));

endmodule

// ----- tb/life_automaton_torus_step_top_tb.sv -----
// Self-checking testbench for life_automaton_torus_step_top: edits, reads and generation
// steps on the toroidal life grid are checked against a behavioural copy of the grid.
// Depends on lats_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module life_automaton_torus_step_top_tb;
   import lats_pkg::*;

   localparam int ROWS = 128;
   localparam int COLS = 128;
   localparam int RANDOM_ITEMS = 76;

   typedef struct packed {
      logic cell_state;
      logic generation_done;
   } expected_cell_type;

   class torus_life_scoreboard_type;
      bit board [ROWS][COLS];
      expected_cell_type pending [$];
      int mismatch_count;
      int checked_count;

      function void advance_board();
         bit nxt [ROWS][COLS];
         int up, dn, lf, rt, n;
         for (int r = 0; r < ROWS; r++) begin
            up = (r + ROWS - 1) % ROWS;
            dn = (r + 1) % ROWS;
            for (int c = 0; c < COLS; c++) begin
               lf = (c + COLS - 1) % COLS;
               rt = (c + 1) % COLS;
               n = board[up][lf] + board[up][c] + board[up][rt] + board[r][lf]
                 + board[r][rt] + board[dn][lf] + board[dn][c] + board[dn][rt];
               if (board[r][c])
                  nxt[r][c] = (n == 2 || n == 3);
               else
                  nxt[r][c] = (n == 3);
            end
         end
         board = nxt;
      endfunction

      function void note_item(lats_mode_type mode, int row, int col, bit val);
         expected_cell_type res;
         int r, c;
         r = row % ROWS;
         c = col % COLS;
         if (mode == MODE_GEN) begin
            advance_board();
            res.cell_state = 1'b0;
            res.generation_done = 1'b1;
         end else begin
            if (mode == MODE_TOGGLE)
               board[r][c] = !board[r][c];
            else if (mode == MODE_SET)
               board[r][c] = val;
            res.cell_state = board[r][c];
            res.generation_done = 1'b0;
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic cell_state, logic generation_done);
         expected_cell_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, cell_state %b generation_done %b",
                     $time, cell_state, generation_done);
            mismatch_count++;
            return;
         end
         want = pending.pop_front();
         checked_count++;
         if (cell_state !== want.cell_state) begin
            $display("%0t: cell_state expected %b got %b", $time, want.cell_state, cell_state);
            mismatch_count++;
         end
         if (generation_done !== want.generation_done) begin
            $display("%0t: generation_done expected %b got %b",
                     $time, want.generation_done, generation_done);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lats_mode_type req_mode = MODE_READ;
   logic [CELL_IDX_W-1:0] req_cell_row = '0;
   logic [CELL_IDX_W-1:0] req_cell_col = '0;
   logic req_set_value = 1'b0;
   logic rsp_valid;
   logic rsp_cell_state;
   logic rsp_generation_done;

   torus_life_scoreboard_type grid_sb = new();
   int items_sent;
   int gens_sent;
   int gens_left = 16;
   bit no_idle;

   life_automaton_torus_step_top #(
      .GRID_ROWS(ROWS),
      .GRID_COLS(COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_cell_row(req_cell_row),
      .req_cell_col(req_cell_col),
      .req_set_value(req_set_value),
      .rsp_valid(rsp_valid),
      .rsp_cell_state(rsp_cell_state),
      .rsp_generation_done(rsp_generation_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d results outstanding", grid_sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         grid_sb.check_result(rsp_cell_state, rsp_generation_done);
   end

   function automatic int wrap_idx(int v, int size);
      return ((v % size) + size) % size;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // held until accepted; start stays high into the next item when no gap follows
   task automatic send_item(lats_mode_type mode, int row, int col, bit val);
      int gap;
      start <= 1'b1;
      req_mode <= mode;
      req_cell_row <= row[CELL_IDX_W-1:0];
      req_cell_col <= col[CELL_IDX_W-1:0];
      req_set_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      grid_sb.note_item(mode, row, col, val);
      items_sent++;
      if (mode == MODE_GEN)
         gens_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_step();
      if (gens_left > 0) begin
         gens_left--;
         send_item(MODE_GEN, $urandom_range(0, 127), $urandom_range(0, 127),
                   1'($urandom_range(0, 1)));
      end
   endtask

   // random 3x3 patch around a random centre, then up to two generations while any remain, and reads nearby
   task automatic plant_and_step();
      int r0, c0, pick;
      r0 = $urandom_range(0, ROWS - 1);
      c0 = $urandom_range(0, COLS - 1);
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
               send_item(MODE_SET, wrap_idx(r0 + dr, ROWS), wrap_idx(c0 + dc, COLS),
                         1'($urandom_range(0, 1)));
            else if (pick == 1)
               send_item(MODE_TOGGLE, wrap_idx(r0 + dr, ROWS), wrap_idx(c0 + dc, COLS),
                         1'($urandom_range(0, 1)));
         end
      end
      random_step();
      if ($urandom_range(0, 3) == 0)
         random_step();
      repeat ($urandom_range(2, 4))
         send_item(MODE_READ, wrap_idx(r0 + $urandom_range(0, 4) - 2, ROWS),
                   wrap_idx(c0 + $urandom_range(0, 4) - 2, COLS),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic noise_item();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         random_step();
      else
         send_item(lats_mode_type'($urandom_range(0, 2)), $urandom_range(0, 127),
                   $urandom_range(0, 127), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners are mutual neighbours on the torus
      send_item(MODE_READ, 0, 0, 1'b0);
      send_item(MODE_TOGGLE, 0, 0, 1'b0);
      send_item(MODE_TOGGLE, 127, 127, 1'b1);
      send_item(MODE_SET, 127, 0, 1'b1);
      send_item(MODE_SET, 0, 127, 1'b0);
      send_item(MODE_READ, 127, 127, 1'b1);
      send_item(MODE_GEN, 127, 127, 1'b1);
      send_item(MODE_READ, 0, 127, 1'b0);
      send_item(MODE_TOGGLE, 0, 0, 1'b1);
      send_item(MODE_SET, 127, 127, 1'b0);
      send_item(MODE_SET, 127, 0, 1'b0);
      send_item(MODE_SET, 0, 127, 1'b0);
      // blinker straddling the row wrap
      send_item(MODE_SET, 127, 64, 1'b1);
      send_item(MODE_SET, 0, 64, 1'b1);
      send_item(MODE_SET, 1, 64, 1'b1);
      send_item(MODE_GEN, 0, 0, 1'b0);
      send_item(MODE_READ, 0, 63, 1'b0);
      send_item(MODE_READ, 0, 65, 1'b1);
      send_item(MODE_READ, 127, 64, 1'b0);
      send_item(MODE_GEN, 85, 42, 1'b1);
      send_item(MODE_READ, 1, 64, 1'b0);
      send_item(MODE_READ, 0, 63, 1'b0);
      send_item(MODE_GEN, 0, 0, 1'b0);
      send_item(MODE_READ, 127, 64, 1'b1);

      while (items_sent < RANDOM_ITEMS + 24) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7)
            plant_and_step();
         else
            noise_item();
      end

      start <= 1'b0;
      while (grid_sb.pending.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d items including %0d generation steps; %0d results checked.",
               items_sent, gens_sent, grid_sb.checked_count);
      $display("Mismatches: %0d, results outstanding: %0d",
               grid_sb.mismatch_count, grid_sb.pending.size());
      if (grid_sb.mismatch_count == 0 && grid_sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- life_automaton_torus_step_top.f -----
+incdir+src
src/lats_pkg.sv
src/lats_cell_rule.sv
src/life_automaton_torus_step_top.sv
tb/life_automaton_torus_step_top_tb.sv
